FILE: rtl/sem_pkg.sv
// Shared types, constants and the magnitude threshold table for the Sobel edge block.
`timescale 1ns / 1ps

package sem_pkg;

   // Field and register widths
   localparam int PIXEL_W    = 8;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int ROW_W      = 12;
   localparam int GRAD_W     = 12;   // signed working width of gx, gy
   localparam int ABS_W      = 10;   // |gx|, |gy| stay at or below 1020
   localparam int SQ_W       = 2 * ABS_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int MAG_W      = 8;

   // Geometry
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MIN_DIM           = 3;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 12'd480;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Scale: result v is valid while 1141^2 * v^2 <= 255^2 * s
   localparam longint unsigned MAG_NUM = 64'd1301881;
   localparam longint unsigned MAG_DEN = 64'd65025;

   // Per-pixel classification handed from the front to the back
   typedef struct packed {
      logic emit;   // interior pixel, produces a result
      logic last;   // result closes the frame
   } sem_flags_type;

   typedef logic [255:0][SUM_W-1:0] thresh_tab_type;

   // Smallest s that yields magnitude v: ceil(MAG_NUM * v^2 / MAG_DEN)
   function automatic thresh_tab_type build_thresh();
      thresh_tab_type   tab;
      longint unsigned  p;
      for (int v = 0; v < 256; v++) begin
         p      = MAG_NUM * longint'(v) * longint'(v);
         tab[v] = SUM_W'((p + MAG_DEN - 64'd1) / MAG_DEN);
      end
      return tab;
   endfunction

   localparam thresh_tab_type THRESH_TAB = build_thresh();

endpackage

FILE: rtl/sem_front.sv
// Front end: configuration registers, raster position counters and pixel classification.
`timescale 1ns / 1ps

module sem_front #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sem_pkg::PIXEL_W-1:0]         req_pixel,
   input  logic                                req_frame_start,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // token out to the queue
   output logic                                tok_valid,
   output logic [sem_pkg::PIXEL_W-1:0]         tok_pixel,
   output logic [COL_W-1:0]                    tok_col,
   output sem_pkg::sem_flags_type              tok_flags,
   input  logic                                queue_full,
   input  logic                                clear_busy
);
   import sem_pkg::*;

   localparam int EW = $clog2(MAX_WIDTH + 1);

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;

   logic [EW-1:0]         eff_w;
   logic [ROW_W-1:0]      eff_h;
   logic [COL_W-1:0]      col_cur;
   logic [ROW_W-1:0]      row_cur;
   logic [ROW_W:0]        row_next;
   logic                  accept;

   assign req_tready = !queue_full && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   // Effective frame size
   always_comb begin
      if (32'(width_ff) < MIN_DIM)
         eff_w = EW'(MIN_DIM);
      else if (32'(width_ff) > MAX_WIDTH)
         eff_w = EW'(MAX_WIDTH);
      else
         eff_w = EW'(width_ff);
      eff_h = (32'(height_ff) < MIN_DIM) ? ROW_W'(MIN_DIM) : height_ff;
   end

   // Position of this pixel and where the next one lands
   always_comb begin
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      row_next = {1'b0, row_cur} + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (EW'(col_cur) + EW'(1) >= eff_w) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, eff_h}) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_IMAGE_WIDTH)
            width_in = csr_wdata;
         if (csr_index == CSR_IMAGE_HEIGHT)
            height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Token to the back end
   assign tok_valid      = accept;
   assign tok_pixel      = req_pixel;
   assign tok_col        = col_cur;
   assign tok_flags.emit = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
   assign tok_flags.last = (row_cur == eff_h - 1'b1) && (EW'(col_cur) == eff_w - 1'b1);

endmodule

FILE: rtl/sem_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps

module sem_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign valid    = (count_ff != 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/sem_back.sv
// Back end: line store, 3x3 window, Sobel sums, magnitude search and result register.
`timescale 1ns / 1ps

module sem_back #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   // token from the queue
   input  logic                          q_valid,
   input  logic [sem_pkg::PIXEL_W-1:0]   q_pixel,
   input  logic [COL_W-1:0]              q_col,
   input  sem_pkg::sem_flags_type        q_flags,
   output logic                          q_pop,
   output logic                          clear_busy,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sem_pkg::MAG_W-1:0]     rsp_edge_value,
   output logic                          rsp_last_of_frame
);
   import sem_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_FETCH  = 8'b0000_0010,
      ST_WINDOW = 8'b0000_0100,
      ST_GRAD   = 8'b0000_1000,
      ST_SQUARE = 8'b0001_0000,
      ST_SUM    = 8'b0010_0000,
      ST_SEARCH = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } back_state_type;

   back_state_type state_ff, state_in;

   // Line store: one word per column, upper byte line r-2, lower byte line r-1
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;
   logic                 mem_we, mem_re;
   logic [COL_W-1:0]     mem_waddr;
   logic [2*PIXEL_W-1:0] mem_wdata;

   logic [COL_W-1:0]     clr_cnt_ff, clr_cnt_in;

   logic [PIXEL_W-1:0]   tok_pixel_ff;
   logic [COL_W-1:0]     tok_col_ff;
   sem_flags_type        tok_flags_ff;

   logic [PIXEL_W-1:0]   win_ff [3][3];   // [row top..bottom][col left..right]
   logic [PIXEL_W-1:0]   win_in [3][3];

   logic [ABS_W-1:0]     gx_abs_ff, gx_abs_in;
   logic [ABS_W-1:0]     gy_abs_ff, gy_abs_in;
   logic [SQ_W-1:0]      sq_x_ff, sq_y_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [2:0]           bit_ff, bit_in;
   logic [MAG_W-1:0]     cand;

   logic                 out_valid_ff, out_valid_in;
   logic [MAG_W-1:0]     out_edge_ff;
   logic                 out_last_ff;
   logic                 out_load;

   logic signed [GRAD_W-1:0] p [3][3];
   logic signed [GRAD_W-1:0] gx_s, gy_s;

   assign clear_busy = (state_ff == ST_CLEAR);
   assign q_pop      = (state_ff == ST_FETCH) && q_valid;
   assign mem_re     = q_pop;
   assign out_load   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);

   // Line store write: clearing sweep, or shift the column down one line
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tok_col_ff;
      mem_wdata = {rd_data_ff[PIXEL_W-1:0], tok_pixel_ff};
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_WINDOW) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         line_mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         rd_data_ff <= line_mem[q_col];
   end

   // Window shifts one column left, new column enters on the right
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            win_in[r][c] = win_ff[r][c];
      end
      if (state_ff == ST_WINDOW) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = rd_data_ff[2*PIXEL_W-1:PIXEL_W];
         win_in[1][2] = rd_data_ff[PIXEL_W-1:0];
         win_in[2][2] = tok_pixel_ff;
      end
   end

   // Sobel sums on the settled window
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            p[r][c] = $signed({{(GRAD_W-PIXEL_W){1'b0}}, win_ff[r][c]});
      end
      gx_s = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) <<< 1) + p[2][2] - p[2][0];
      gy_s = p[2][0] - p[0][0] + ((p[2][1] - p[0][1]) <<< 1) + p[2][2] - p[0][2];
      gx_abs_in = gx_s[GRAD_W-1] ? ABS_W'(-gx_s) : ABS_W'(gx_s);
      gy_abs_in = gy_s[GRAD_W-1] ? ABS_W'(-gy_s) : ABS_W'(gy_s);
   end

   // Magnitude: binary search of the threshold table, one bit per cycle
   assign cand = mag_ff | (MAG_W'(1) << bit_ff);

   always_comb begin
      mag_in = mag_ff;
      bit_in = bit_ff;
      if (state_ff == ST_SUM) begin
         mag_in = '0;
         bit_in = 3'd7;
      end else if (state_ff == ST_SEARCH) begin
         if (sum_ff >= THRESH_TAB[cand])
            mag_in = cand;
         bit_in = bit_ff - 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == COL_W'(MAX_WIDTH - 1))
               state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (q_valid)
               state_in = ST_WINDOW;
         end
         ST_WINDOW: begin
            state_in = tok_flags_ff.emit ? ST_GRAD : ST_FETCH;
         end
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (bit_ff == 3'd0)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load)
               state_in = ST_FETCH;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
               win_ff[r][c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
         win_ff       <= win_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (q_pop) begin
         tok_pixel_ff <= q_pixel;
         tok_col_ff   <= q_col;
         tok_flags_ff <= q_flags;
      end
      if (state_ff == ST_GRAD) begin
         gx_abs_ff <= gx_abs_in;
         gy_abs_ff <= gy_abs_in;
      end
      if (state_ff == ST_SQUARE) begin
         sq_x_ff <= gx_abs_ff * gx_abs_ff;
         sq_y_ff <= gy_abs_ff * gy_abs_ff;
      end
      if (state_ff == ST_SUM)
         sum_ff <= {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      mag_ff <= mag_in;
      bit_ff <= bit_in;
      if (out_load) begin
         out_edge_ff <= mag_ff;
         out_last_ff <= tok_flags_ff.last;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_edge_value    = out_edge_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

FILE: rtl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 gradient magnitude block.
`timescale 1ns / 1ps

// Takes 8-bit grayscale pixels in raster order and returns, for every interior
// pixel, floor(255*sqrt(gx^2+gy^2)/1141) saturated at 255; border pixels give
// no result. A result appears once the window's bottom-right pixel has come in,
// and tlast marks the last result of the frame. tuser on a request starts a new
// frame. The front end counts positions and feeds a two-entry queue; the back
// end works one pixel at a time: a pixel with no result takes a line store read,
// then write-back and window shift; a pixel with a result also passes through
// gradient, squaring, sum and the 8-step threshold search of the magnitude unit.
// After reset all MAX_WIDTH line store entries are cleared, during
// which req_tready stays low; register writes are taken throughout. Change the
// frame size only while the block is idle.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel
   input  logic        req_tuser,    // [0] frame_start
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] edge_value
   output logic        rsp_tlast,    // last_of_frame
   // configuration
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import sem_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int TOK_W  = PIXEL_W + COL_W + $bits(sem_flags_type);

   logic               tok_valid;
   logic [PIXEL_W-1:0] tok_pixel;
   logic [COL_W-1:0]   tok_col;
   sem_flags_type      tok_flags;
   logic               queue_full;
   logic               clear_busy;

   logic               q_valid;
   logic               q_pop;
   logic [TOK_W-1:0]   q_data;
   logic [PIXEL_W-1:0] q_pixel;
   logic [COL_W-1:0]   q_col;
   sem_flags_type      q_flags;

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_pixel       (req_tdata),
      .req_frame_start (req_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .tok_valid       (tok_valid),
      .tok_pixel       (tok_pixel),
      .tok_col         (tok_col),
      .tok_flags       (tok_flags),
      .queue_full      (queue_full),
      .clear_busy      (clear_busy)
   );

   sem_queue #(
      .DATA_W (TOK_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_valid),
      .push_data ({tok_flags, tok_col, tok_pixel}),
      .full      (queue_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   assign q_pixel = q_data[PIXEL_W-1:0];
   assign q_col   = q_data[PIXEL_W +: COL_W];
   assign q_flags = sem_flags_type'(q_data[TOK_W-1 -: $bits(sem_flags_type)]);

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pixel           (q_pixel),
      .q_col             (q_col),
      .q_flags           (q_flags),
      .q_pop             (q_pop),
      .clear_busy        (clear_busy),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_edge_value    (rsp_tdata),
      .rsp_last_of_frame (rsp_tlast)
   );

endmodule

FILE: rtl/sem_checker.sv
// Port-level assertions for the Sobel edge block and the bind that attaches them.
`timescale 1ns / 1ps

module sem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // No stale result survives reset
   a_rsp_cleared: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Line store clear keeps requests off right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during line store clear");

   // A stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: test/tb_top.sv
// Self-checking testbench for the Sobel edge block: directed frames, size limits, random frames.
`timescale 1ns / 1ps

module tb_top;
   import sem_pkg::*;

   localparam int LINE_MAX     = MAX_WIDTH_DEFAULT;
   localparam int SETTLE_TICKS = 80;      // covers two queued pixels plus one in the back end
   localparam int QUIET_LIMIT  = 20000;   // clearing pass after reset covers LINE_MAX entries
   localparam int RANDOM_ITEMS = 1000;
   localparam longint unsigned SCALE_DIV = 1141;
   localparam longint unsigned SCALE_MUL = 255;

   typedef struct packed {
      logic [7:0] level;
      logic       last;
   } grad_result_type;

   typedef enum int unsigned {PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} pix_style_type;

   // Block ports
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [7:0]            req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire  [7:0]            rsp_tdata;
   wire                   rsp_tlast;

   // Predictor state: shadow of the line stores, window, position and frame size
   logic [7:0]            prev_lines [2*LINE_MAX];
   logic [7:0]            win [3][3];
   int unsigned           col_pos    = 0;
   int unsigned           row_pos    = 0;
   logic [CSR_DATA_W-1:0] width_reg  = WIDTH_RESET;
   logic [CSR_DATA_W-1:0] height_reg = HEIGHT_RESET;

   grad_result_type       expected_edges [$];
   int unsigned           mismatches   = 0;
   int unsigned           items_sent   = 0;
   int unsigned           quiet_cycles = 0;
   int unsigned           ready_hold   = 0;
   bit                    stalls_on    = 1'b1;

   sobel_edge_magnitude #(.MAX_WIDTH(LINE_MAX)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Effective line length, clamped to 3..LINE_MAX
   function automatic int unsigned line_len();
      int unsigned w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   // Effective frame height, at least 3
   function automatic int unsigned frame_rows();
      int unsigned h;
      h = height_reg;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   // Largest level in 0..255 with (1141*level)^2 <= 255^2 * energy, by bisection
   function automatic logic [7:0] grad_level(longint unsigned energy);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if ((SCALE_DIV * mid) * (SCALE_DIV * mid) <= SCALE_MUL * SCALE_MUL * energy) lo = mid;
         else hi = mid - 1;
      end
      return 8'(lo);
   endfunction

   function automatic logic [7:0] pick_pixel(pix_style_type style);
      case (style)
         PIX_UNIFORM: return 8'($urandom);
         PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default:     return 8'(100 + $urandom_range(0, 12));
      endcase
   endfunction

   // Advance the shadow state by one accepted pixel; queue the result it causes
   task automatic predict_pixel(input logic [7:0] pix, input logic fs);
      int unsigned     w, h, c;
      logic [7:0]      up2, up1;
      int              gx, gy;
      grad_result_type res;
      w = line_len();
      h = frame_rows();
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c   = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
      up2 = prev_lines[LINE_MAX + c];
      up1 = prev_lines[c];
      prev_lines[LINE_MAX + c] = up1;
      prev_lines[c]            = pix;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = pix;

      if (row_pos >= 2 && col_pos >= 2) begin
         gx = int'(win[0][2]) - int'(win[0][0])
            + 2 * (int'(win[1][2]) - int'(win[1][0]))
            + int'(win[2][2]) - int'(win[2][0]);
         gy = int'(win[2][0]) - int'(win[0][0])
            + 2 * (int'(win[2][1]) - int'(win[0][1]))
            + int'(win[2][2]) - int'(win[0][2]);
         res.level = grad_level(longint'(gx * gx) + longint'(gy * gy));
         res.last  = (row_pos == h - 1) && (col_pos == w - 1);
         expected_edges.push_back(res);
      end

      // position of the next pixel
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end else begin
         col_pos++;
      end
   endtask

   // One request: optional idle burst, then hold until accepted
   task automatic send_pixel(input logic [7:0] pix, input logic fs);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      predict_pixel(pix, fs);
      items_sent++;
   endtask

   // Let all expected results out, then give pixels with no result time to retire
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      @(posedge clock);
   endtask

   // Reset geometry, clamped minimum size, frame wrap and restart mid-frame
   task automatic test_smallest_frame();
      logic [7:0] bright_top [9] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF,
                                     8'h00, 8'h00, 8'h00};
      logic [7:0] soft_ramp [9]  = '{8'h10, 8'h11, 8'h12, 8'h12, 8'h13, 8'h14,
                                     8'h14, 8'h15, 8'h17};
      // a few pixels at the reset size, no result possible yet
      for (int i = 0; i < 3; i++) send_pixel(8'hAA >> i, i == 0);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 12'd0);    // below range, acts as 3
      write_reg(CSR_IMAGE_HEIGHT, 12'd2);   // below range, acts as 3
      foreach (bright_top[i]) send_pixel(bright_top[i], i == 0);
      // counters wrap on their own; cut the next frame short with a frame start
      for (int i = 0; i < 4; i++) send_pixel(8'h55 ^ 8'(i), 1'b0);
      foreach (soft_ramp[i]) send_pixel(soft_ramp[i], i == 0);
      drain();
   endtask

   // Widest line setting, then a mid-line shrink that ends the line at once
   task automatic test_widest_line();
      write_reg(CSR_IMAGE_WIDTH, 12'hFFF);  // clamps to LINE_MAX
      write_reg(CSR_IMAGE_HEIGHT, 12'd3);
      for (int i = 0; i < 40; i++) send_pixel(pick_pixel(PIX_UNIFORM), i == 0);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 12'd5);
      for (int i = 0; i < 16; i++) send_pixel(pick_pixel(PIX_EXTREME), 1'b0);
      drain();
   endtask

   // Tallest frame setting, then a mid-frame height cut
   task automatic test_tallest_setting();
      write_reg(CSR_IMAGE_WIDTH, 12'd4);
      write_reg(CSR_IMAGE_HEIGHT, 12'hFFF);
      for (int i = 0; i < 26; i++) send_pixel(pick_pixel(PIX_UNIFORM), i == 0);
      drain();
      write_reg(CSR_IMAGE_HEIGHT, 12'd3);
      for (int i = 0; i < 14; i++) send_pixel(pick_pixel(PIX_FLAT), 1'b0);
      drain();
   endtask

   // Random frame sizes and content, with truncated frames, restarts and resizes
   task automatic test_random_frames();
      int unsigned   base, count, done;
      pix_style_type style;
      bit            fs_first;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         drain();
         done      = items_sent - base;
         stalls_on = (done < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) != 0) write_reg(CSR_IMAGE_WIDTH, 12'($urandom_range(0, 12)));
         if ($urandom_range(0, 2) != 0) write_reg(CSR_IMAGE_HEIGHT, 12'($urandom_range(0, 8)));
         style    = pix_style_type'($urandom_range(0, 2));
         count    = line_len() * frame_rows();
         if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
         fs_first = ($urandom_range(0, 7) != 0);
         for (int i = 0; i < count; i++) begin
            // pause mid-frame and change the size
            if (i > 0 && $urandom_range(0, 59) == 0) begin
               drain();
               if ($urandom_range(0, 1) != 0)
                  write_reg(CSR_IMAGE_WIDTH, 12'($urandom_range(0, 12)));
               else
                  write_reg(CSR_IMAGE_HEIGHT, 12'($urandom_range(0, 8)));
            end
            send_pixel(pick_pixel(style),
                       (i == 0 && fs_first) || ($urandom_range(0, 299) == 0));
         end
      end
   endtask

   initial begin
      foreach (prev_lines[i]) prev_lines[i] = 8'h00;
      foreach (win[r, c]) win[r][c] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_smallest_frame();
      test_widest_line();
      test_tallest_setting();
      test_random_frames();

      stalls_on = 1'b0;
      drain();
      if (mismatches == 0 && expected_edges.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response side ready: random stall bursts while stalls are on
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         ready_hold = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      grad_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result level=%0d last=%0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_edges.pop_front();
            if (rsp_tdata !== want.level || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: level exp=%0d got=%0d, last exp=%0b got=%0b",
                           want.level, rsp_tdata, want.last, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request or result
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

FILE: sobel_edge_magnitude.f
rtl/sem_pkg.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude.sv
rtl/sem_checker.sv
test/tb_top.sv
